// ----- hw/rtl/brush_dab_interpolator_unit_defines.svh -----
// ----------------------------------------------------------------------------
// brush_dab_interpolator_unit_defines
// assertion macros shared by the checker of the dab interpolator
// ----------------------------------------------------------------------------
`ifndef BRUSH_DAB_INTERPOLATOR_UNIT_DEFINES_SVH
`define BRUSH_DAB_INTERPOLATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define BDI_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BDI_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/bdi_pkg.sv -----
// ----------------------------------------------------------------------------
// bdi_pkg
// types and constants of the brush dab interpolator
// ----------------------------------------------------------------------------
package bdi_pkg;

  localparam int unsigned COORD_W    = 20;
  localparam int unsigned SIZE_W     = 14;
  localparam int unsigned RAD_W      = 13;
  localparam int unsigned COLOR_W    = 32;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned SIZE_MAX   = (1 << SIZE_W) - 1;

  localparam logic [SIZE_W-1:0]  SIZE_RESET  = 14'd160;
  localparam logic [COLOR_W-1:0] COLOR_RESET = 32'd255;

  typedef enum logic [MODE_W-1:0] {
    MODE_PRESS   = 2'd0,
    MODE_DRAG    = 2'd1,
    MODE_RELEASE = 2'd2
  } mode_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_BEGIN  = 2'd0,
    KIND_CONT   = 2'd1,
    KIND_FINISH = 2'd2
  } dab_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIZE  = 2'd0,
    CFG_COLOR = 2'd1,
    CFG_ERASE = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BEGIN,
    ST_DIFF,
    ST_CHECK,
    ST_SQY,
    ST_SUM,
    ST_SEARCH,
    ST_DIV,
    ST_PREP,
    ST_DAB,
    ST_FINISH
  } ctrl_state_e;

  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic signed [COORD_W-1:0] x_pos;
    logic signed [COORD_W-1:0] y_pos;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]         dab_kind;
    logic signed [COORD_W-1:0] dab_x;
    logic signed [COORD_W-1:0] dab_y;
    logic [RAD_W-1:0]          dab_radius;
    logic [COLOR_W-1:0]        dab_color;
    logic                      dab_erase;
    logic                      last;
  } out_item_t;

  typedef struct packed {
    logic [SIZE_W-1:0]  size;
    logic [COLOR_W-1:0] color;
    logic               erase;
  } cfg_t;

  typedef struct packed {
    logic load_in;
    logic calc_diff;
    logic sq_x;
    logic sq_y;
    logic sum_sq;
    logic search_init;
    logic search_step;
    logic steps_found;
    logic steps_max;
    logic div_init;
    logic div_step;
    logic prep;
    logic dab_step;
    logic cont_last;
    logic emit_begin;
    logic emit_finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic zero_dist;
    logic capped;
    logic search_done;
    logic div_done;
    logic dab_last;
    logic out_free;
  } dp_status_t;

endpackage

// ----- hw/rtl/bdi_cfg.sv -----
// ----------------------------------------------------------------------------
// bdi_cfg
// brush configuration registers with size saturation
// ----------------------------------------------------------------------------
module bdi_cfg #(
  parameter int unsigned FRAC_BITS = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bdi_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [bdi_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output bdi_pkg::cfg_t                    cfg_o
);
  import bdi_pkg::*;

  cfg_t              cfg_d, cfg_q;
  logic [SIZE_W-1:0] size_one;
  logic [SIZE_W-1:0] size_wr;

  assign size_one = SIZE_W'(1) << FRAC_BITS;
  assign size_wr  = cfg_data_i[SIZE_W-1:0];

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SIZE:  cfg_d.size  = (size_wr < size_one) ? size_one : size_wr;
        CFG_COLOR: cfg_d.color = cfg_data_i[COLOR_W-1:0];
        CFG_ERASE: cfg_d.erase = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{size: SIZE_RESET, color: COLOR_RESET, erase: 1'b0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/bdi_ctrl.sv -----
// ----------------------------------------------------------------------------
// bdi_ctrl
// sequencer for one pointer event: distance, step search, divide, dabs
// ----------------------------------------------------------------------------
module bdi_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [bdi_pkg::MODE_W-1:0]    in_mode_i,
  output logic                          in_stall_o,
  input  bdi_pkg::dp_status_t           status_i,
  output bdi_pkg::ctrl_cmd_t            cmd_o
);
  import bdi_pkg::*;

  ctrl_state_e state_d, state_q;
  logic        drawing_d, drawing_q;
  logic        rel_d, rel_q;

  always_comb begin
    state_d       = state_q;
    drawing_d     = drawing_q;
    rel_d         = rel_q;
    in_stall_o    = 1'b1;
    cmd_o         = '0;
    cmd_o.cont_last = !rel_q;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          rel_d = (in_mode_i == MODE_RELEASE);
          unique case (in_mode_i)
            MODE_PRESS: state_d = ST_BEGIN;
            MODE_DRAG, MODE_RELEASE: begin
              if (drawing_q) state_d = ST_DIFF;
            end
            default: ;
          endcase
        end
      end
      ST_BEGIN: begin
        if (status_i.out_free) begin
          cmd_o.emit_begin = 1'b1;
          drawing_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_DIFF: begin
        cmd_o.calc_diff = 1'b1;
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        priority if (status_i.zero_dist) begin
          state_d = rel_q ? ST_FINISH : ST_IDLE;
        end else if (status_i.capped) begin
          cmd_o.steps_max = 1'b1;
          cmd_o.div_init = 1'b1;
          state_d = ST_DIV;
        end else begin
          cmd_o.sq_x = 1'b1;
          state_d = ST_SQY;
        end
      end
      ST_SQY: begin
        cmd_o.sq_y = 1'b1;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum_sq = 1'b1;
        cmd_o.search_init = 1'b1;
        state_d = ST_SEARCH;
      end
      ST_SEARCH: begin
        cmd_o.search_step = 1'b1;
        if (status_i.search_done) begin
          cmd_o.steps_found = 1'b1;
          cmd_o.div_init = 1'b1;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (status_i.div_done) begin
          state_d = ST_PREP;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d = ST_DAB;
      end
      ST_DAB: begin
        if (status_i.out_free) begin
          cmd_o.dab_step = 1'b1;
          if (status_i.dab_last) state_d = rel_q ? ST_FINISH : ST_IDLE;
        end
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.emit_finish = 1'b1;
          drawing_d = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      drawing_q <= 1'b0;
      rel_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      drawing_q <= drawing_d;
      rel_q     <= rel_d;
    end
  end

endmodule

// ----- hw/rtl/bdi_datapath.sv -----
// ----------------------------------------------------------------------------
// bdi_datapath
// point registers, squarer, step search, bit-serial dividers, dab stepper
// and output register
// ----------------------------------------------------------------------------
module bdi_datapath #(
  parameter int unsigned MAX_DABS = 63
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bdi_pkg::in_item_t     in_data_i,
  input  bdi_pkg::cfg_t         cfg_i,
  input  bdi_pkg::ctrl_cmd_t    cmd_i,
  output bdi_pkg::dp_status_t   status_o,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output bdi_pkg::out_item_t    out_data_o
);
  import bdi_pkg::*;

  localparam int unsigned CNTW = $clog2(MAX_DABS + 1);
  localparam int unsigned SCW  = $clog2(MAX_DABS + 2);
  localparam int unsigned MAGW = COORD_W + 1;
  localparam int unsigned QW   = MAGW + 1;
  localparam int unsigned PXW  = QW + 1;
  localparam int unsigned RW   = $clog2((MAX_DABS + 2) * SIZE_MAX + 1);
  localparam int unsigned MW   = (MAGW > RW) ? MAGW : RW;
  localparam int unsigned PW   = 2 * MW + 7;
  localparam int unsigned CAPW = MAGW + 3 + CNTW + SIZE_W;
  localparam int unsigned ACW  = CNTW + 2;
  localparam int unsigned DCW  = $clog2(MAGW + 1);

  // lane 0 is x, lane 1 is y
  logic signed [COORD_W-1:0] cur_q   [2];
  logic signed [COORD_W-1:0] prev_q  [2];
  logic signed [COORD_W-1:0] pos_q   [2];
  logic                      dneg_q  [2];
  logic [MAGW-1:0]           ax_q    [2];
  logic [MAGW-1:0]           quo_q   [2];
  logic [CNTW-1:0]           rem_q   [2];
  logic signed [QW-1:0]      qstep_q [2];
  logic [CNTW:0]             rstep_q [2];
  logic [ACW-1:0]            racc_q  [2];

  logic signed [MAGW-1:0]    diff     [2];
  logic [MAGW-1:0]           mag      [2];
  logic [CNTW:0]             trial    [2];
  logic                      trial_ge [2];
  logic [CNTW:0]             trial_sub[2];
  logic [CNTW:0]             rem2     [2];
  logic signed [QW-1:0]      qstep_d  [2];
  logic [CNTW:0]             rstep_d  [2];
  logic [ACW-1:0]            rsum     [2];
  logic                      carry    [2];
  logic [ACW-1:0]            racc_d   [2];
  logic [PXW-1:0]            pos_sum  [2];
  logic signed [COORD_W-1:0] pos_d    [2];
  logic [CAPW-1:0]           cap_lhs  [2];

  logic [CNTW:0]     twos;
  logic [CAPW-1:0]   cap_d;
  logic [MW-1:0]     mul_a;
  logic [2*MW-1:0]   mul_p;
  logic [2*MW-1:0]   prod_q, acc_q;
  logic [PW-1:0]     d64_q;
  logic [RW-1:0]     r_q;
  logic [SCW-1:0]    si_q;
  logic [CNTW-1:0]   pi_q;
  logic              pv_q;
  logic [CNTW-1:0]   steps_q;
  logic [CNTW-1:0]   di_q;
  logic [DCW-1:0]    dcnt_q;
  logic              out_valid_d, out_valid_q;
  out_item_t         out_d, out_q;

  assign twos  = {steps_q, 1'b0};
  assign cap_d = CAPW'(cfg_i.size) * CAPW'(MAX_DABS);

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      diff[l]      = MAGW'(cur_q[l]) - MAGW'(prev_q[l]);
      mag[l]       = diff[l][MAGW-1] ? MAGW'(-diff[l]) : MAGW'(diff[l]);
      cap_lhs[l]   = CAPW'({ax_q[l], 3'b000});
      // restoring divide of |d| by steps, one quotient bit per cycle
      trial[l]     = {rem_q[l], quo_q[l][MAGW-1]};
      trial_ge[l]  = (trial[l] >= {1'b0, steps_q});
      trial_sub[l] = trial[l] - {1'b0, steps_q};
      // floor division of 2d by 2*steps from the magnitude quotient
      rem2[l]      = {rem_q[l], 1'b0};
      if (dneg_q[l] && (rem_q[l] != '0)) begin
        qstep_d[l] = -(QW'(quo_q[l]) + QW'(1));
        rstep_d[l] = twos - rem2[l];
      end else if (dneg_q[l]) begin
        qstep_d[l] = -QW'(quo_q[l]);
        rstep_d[l] = rem2[l];
      end else begin
        qstep_d[l] = QW'(quo_q[l]);
        rstep_d[l] = rem2[l];
      end
      // incremental rounding: remainder carries one unit into the position
      rsum[l]    = racc_q[l] + ACW'(rstep_q[l]);
      carry[l]   = (rsum[l] >= ACW'(twos));
      racc_d[l]  = carry[l] ? (rsum[l] - ACW'(twos)) : rsum[l];
      pos_sum[l] = PXW'(pos_q[l]) + PXW'(qstep_q[l]) + PXW'(carry[l]);
      pos_d[l]   = pos_sum[l][COORD_W-1:0];
    end
  end

  always_comb begin
    priority if (cmd_i.sq_x) mul_a = MW'(ax_q[0]);
    else if (cmd_i.sq_y)     mul_a = MW'(ax_q[1]);
    else                     mul_a = MW'(r_q);
  end
  assign mul_p = mul_a * mul_a;

  assign status_o.zero_dist   = (ax_q[0] == '0) && (ax_q[1] == '0);
  assign status_o.capped      = (cap_lhs[0] > cap_d) || (cap_lhs[1] > cap_d);
  assign status_o.search_done = pv_q && ((PW'(prod_q) >= d64_q) ||
                                         (pi_q == CNTW'(MAX_DABS)));
  assign status_o.div_done    = (dcnt_q == '0);
  assign status_o.dab_last    = (di_q == steps_q);
  assign status_o.out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d.dab_radius = cfg_i.size[SIZE_W-1:1];
    out_d.dab_color  = cfg_i.color;
    out_d.dab_erase  = cfg_i.erase;
    priority if (cmd_i.emit_begin) begin
      out_valid_d    = 1'b1;
      out_d.dab_kind = KIND_BEGIN;
      out_d.dab_x    = cur_q[0];
      out_d.dab_y    = cur_q[1];
      out_d.last     = 1'b1;
    end else if (cmd_i.dab_step) begin
      out_valid_d    = 1'b1;
      out_d.dab_kind = KIND_CONT;
      out_d.dab_x    = pos_d[0];
      out_d.dab_y    = pos_d[1];
      out_d.last     = status_o.dab_last && cmd_i.cont_last;
    end else if (cmd_i.emit_finish) begin
      out_valid_d    = 1'b1;
      out_d.dab_kind = KIND_FINISH;
      out_d.dab_x    = '0;
      out_d.dab_y    = '0;
      out_d.last     = 1'b1;
    end else begin
      out_d = out_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pv_q        <= 1'b0;
      dcnt_q      <= '0;
      for (int l = 0; l < 2; l++) prev_q[l] <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cmd_i.search_init) pv_q <= 1'b0;
      else if (cmd_i.search_step) pv_q <= 1'b1;
      if (cmd_i.div_init) dcnt_q <= DCW'(MAGW);
      else if (cmd_i.div_step) dcnt_q <= dcnt_q - DCW'(1);
      if (cmd_i.emit_begin || (cmd_i.dab_step && status_o.dab_last)) begin
        for (int l = 0; l < 2; l++) prev_q[l] <= cur_q[l];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (cmd_i.load_in) begin
      cur_q[0] <= in_data_i.x_pos;
      cur_q[1] <= in_data_i.y_pos;
    end
    for (int l = 0; l < 2; l++) begin
      if (cmd_i.calc_diff) begin
        dneg_q[l] <= diff[l][MAGW-1];
        ax_q[l]   <= mag[l];
      end
      if (cmd_i.div_init) begin
        quo_q[l] <= ax_q[l];
        rem_q[l] <= '0;
      end else if (cmd_i.div_step) begin
        quo_q[l] <= {quo_q[l][MAGW-2:0], trial_ge[l]};
        rem_q[l] <= trial_ge[l] ? trial_sub[l][CNTW-1:0] : trial[l][CNTW-1:0];
      end
      if (cmd_i.prep) begin
        qstep_q[l] <= qstep_d[l];
        rstep_q[l] <= rstep_d[l];
        racc_q[l]  <= ACW'(steps_q);
        pos_q[l]   <= prev_q[l];
      end else if (cmd_i.dab_step) begin
        racc_q[l] <= racc_d[l];
        pos_q[l]  <= pos_d[l];
      end
    end
    if (cmd_i.sq_x || cmd_i.sq_y || cmd_i.search_step) prod_q <= mul_p;
    if (cmd_i.sq_y) acc_q <= prod_q;
    if (cmd_i.sum_sq) d64_q <= (PW'(acc_q) + PW'(prod_q)) << 6;
    if (cmd_i.search_init) begin
      r_q  <= RW'(cfg_i.size);
      si_q <= SCW'(1);
    end else if (cmd_i.search_step) begin
      r_q  <= r_q + RW'(cfg_i.size);
      si_q <= si_q + SCW'(1);
      pi_q <= si_q[CNTW-1:0];
    end
    if (cmd_i.steps_max) steps_q <= CNTW'(MAX_DABS);
    else if (cmd_i.steps_found) steps_q <= pi_q;
    if (cmd_i.prep) di_q <= CNTW'(1);
    else if (cmd_i.dab_step) di_q <= di_q + CNTW'(1);
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- hw/rtl/brush_dab_interpolator_unit.sv -----
// ----------------------------------------------------------------------------
// brush_dab_interpolator_unit
// turns pointer events into brush dabs spaced at an eighth of the brush size
// ----------------------------------------------------------------------------
// channel  handshake                    payload
// in       in_valid_i / in_stall_o      bdi_pkg::in_item_t
// out      out_valid_o / out_stall_i    bdi_pkg::out_item_t
// cfg      cfg_we_i                     cfg_idx_i, cfg_data_i
//
// a press emits its begin dab once the output register is free; a drag or
// release squares the distance and searches the step count (both skipped when
// the step count caps), runs the bit-serial dividers and then emits one dab per
// step, at most 63 dabs plus a finish word.
// reset clears the stroke state and loads the register defaults, no sweep.
// one event is worked on at a time; output stall holds the dab loop, and the
// next event is taken as soon as the last word sits in the output register.
// ----------------------------------------------------------------------------
module brush_dab_interpolator_unit #(
  parameter int unsigned MAX_DABS  = 63,
  parameter int unsigned FRAC_BITS = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  bdi_pkg::in_item_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output bdi_pkg::out_item_t              out_data_o,
  input  logic                            cfg_we_i,
  input  logic [bdi_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bdi_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import bdi_pkg::*;

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  bdi_cfg #(
    .FRAC_BITS (FRAC_BITS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  bdi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_mode_i  (in_data_i.mode),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bdi_datapath #(
    .MAX_DABS (MAX_DABS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- hw/rtl/bdi_chk.sv -----
// ----------------------------------------------------------------------------
// bdi_chk
// port-level checks of the dab interpolator, bound to the top level
// ----------------------------------------------------------------------------
`include "brush_dab_interpolator_unit_defines.svh"

module bdi_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input bdi_pkg::out_item_t  out_data_o
);
  import bdi_pkg::*;

  `BDI_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "stalled word dropped")
  `BDI_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_data_o), "stalled word changed")
  `BDI_ASSERT_SAME(a_finish_form, clk_i, rst_ni, out_valid_o && (out_data_o.dab_kind == KIND_FINISH), (out_data_o.dab_x == '0) && (out_data_o.dab_y == '0) && out_data_o.last, "finish word malformed")
  `BDI_ASSERT_SAME(a_begin_last, clk_i, rst_ni, out_valid_o && (out_data_o.dab_kind == KIND_BEGIN), out_data_o.last, "begin dab not marked last")

endmodule

bind brush_dab_interpolator_unit bdi_chk u_bdi_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ----- sim/tb_brush_dab_interpolator_unit.sv -----
// ----------------------------------------------------------------------------
// tb_brush_dab_interpolator_unit
// self-checking bench for the brush dab interpolator: pointer events go in
// through the valid/stall channel, a scoreboard predicts every dab word from
// its own copy of stroke state and brush registers, and each word that comes
// out is compared field by field under several idle, stall and brush settings
// ----------------------------------------------------------------------------
import bdi_pkg::*;

localparam int MAX_STEPS  = 63;
localparam int SIZE_FLOOR = 16;  // 1.0 with four fraction bits
localparam int SHOW_LIMIT = 40;

class dab_scoreboard;
  logic [SIZE_W-1:0]  size_reg;
  logic [COLOR_W-1:0] color_reg;
  logic               erase_reg;
  bit                 drawing;
  longint             prev_x;
  longint             prev_y;
  out_item_t          pending_dabs[$];
  int unsigned        mismatches;
  int unsigned        words_seen;

  function new();
    size_reg   = SIZE_RESET;
    color_reg  = COLOR_RESET;
    erase_reg  = 1'b0;
    drawing    = 1'b0;
    prev_x     = 0;
    prev_y     = 0;
    mismatches = 0;
    words_seen = 0;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_SIZE: begin
        if (val[SIZE_W-1:0] < SIZE_FLOOR) size_reg = SIZE_W'(SIZE_FLOOR);
        else size_reg = val[SIZE_W-1:0];
      end
      CFG_COLOR: color_reg = val;
      CFG_ERASE: erase_reg = val[0];
      default: ;
    endcase
  endfunction

  function longint floor_div(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  function void push_dab(dab_kind_e kind, longint x, longint y);
    out_item_t d;
    d.dab_kind   = kind;
    d.dab_x      = x[COORD_W-1:0];
    d.dab_y      = y[COORD_W-1:0];
    d.dab_radius = size_reg[SIZE_W-1:1];
    d.dab_color  = color_reg;
    d.dab_erase  = erase_reg;
    d.last       = 1'b0;
    pending_dabs.push_back(d);
  endfunction

  // predicts the words that one accepted event causes
  function void note_event(in_item_t ev);
    longint    cx, cy, dx, dy, ax, ay, sz, steps;
    int        first;
    out_item_t tail;
    cx    = longint'(ev.x_pos);
    cy    = longint'(ev.y_pos);
    first = pending_dabs.size();
    if (ev.mode == MODE_PRESS) begin
      drawing = 1'b1;
      prev_x  = cx;
      prev_y  = cy;
      push_dab(KIND_BEGIN, cx, cy);
    end else if ((ev.mode == MODE_DRAG || ev.mode == MODE_RELEASE) && drawing) begin
      dx = cx - prev_x;
      dy = cy - prev_y;
      if (dx != 0 || dy != 0) begin
        sz = longint'(size_reg);
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        // spacing is size/8, so compare (i*size)^2 against 64*dist^2
        if (8 * ax > MAX_STEPS * sz || 8 * ay > MAX_STEPS * sz) begin
          steps = MAX_STEPS;
        end else begin
          steps = 0;
          for (longint i = 1; i <= MAX_STEPS && steps == 0; i++) begin
            if ((i * sz) * (i * sz) >= 64 * (ax * ax + ay * ay)) steps = i;
          end
          if (steps == 0) steps = MAX_STEPS;
        end
        // round to nearest, ties toward plus infinity
        for (longint i = 1; i <= steps; i++) begin
          push_dab(KIND_CONT, prev_x + floor_div(2 * dx * i + steps, 2 * steps),
                   prev_y + floor_div(2 * dy * i + steps, 2 * steps));
        end
      end
      prev_x = cx;
      prev_y = cy;
      if (ev.mode == MODE_RELEASE) begin
        push_dab(KIND_FINISH, 0, 0);
        drawing = 1'b0;
      end
    end
    if (pending_dabs.size() > first) begin
      tail      = pending_dabs.pop_back();
      tail.last = 1'b1;
      pending_dabs.push_back(tail);
    end
  endfunction

  task report(string msg);
    if (mismatches < SHOW_LIMIT) $display("mismatch: %s", msg);
    mismatches++;
  endtask

  task compare_field(string name, logic [31:0] got_v, logic [31:0] want_v);
    if (got_v !== want_v)
      report($sformatf("word %0d %s got %h want %h", words_seen, name, got_v, want_v));
  endtask

  task check_dab(out_item_t got);
    out_item_t want;
    if (pending_dabs.size() == 0) begin
      report($sformatf("word %0d arrived with nothing predicted, kind %0d",
                       words_seen, got.dab_kind));
    end else begin
      want = pending_dabs.pop_front();
      compare_field("dab_kind", 32'(got.dab_kind), 32'(want.dab_kind));
      compare_field("dab_x", 32'(got.dab_x), 32'(want.dab_x));
      compare_field("dab_y", 32'(got.dab_y), 32'(want.dab_y));
      compare_field("dab_radius", 32'(got.dab_radius), 32'(want.dab_radius));
      compare_field("dab_color", got.dab_color, want.dab_color);
      compare_field("dab_erase", 32'(got.dab_erase), 32'(want.dab_erase));
      compare_field("last", 32'(got.last), 32'(want.last));
    end
    words_seen++;
  endtask
endclass

module tb_brush_dab_interpolator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 11;
  localparam int SETTLE_CYCLES  = 180;
  localparam int HOLDOFF_CYCLES = 700;
  localparam int WATCHDOG_LIMIT = 5000;

  localparam logic [MODE_W-1:0]    MODE_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;
  localparam longint COORD_HI = 524287;
  localparam longint COORD_LO = -524288;

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_item_t              in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_item_t             out_data_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  int          idle_pct       = 0;
  int          stall_pct      = 0;
  int unsigned holdoff_ticket = 0;
  int unsigned holdoff_served = 0;
  int unsigned holdoff_left   = 0;
  int unsigned quiet_cycles   = 0;
  int          stroke_items;
  logic        stall_next;

  dab_scoreboard sb = new();

  brush_dab_interpolator_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // receiver: random stall, or a long hold-off when one is requested
  always @(posedge clk_i) begin
    if (holdoff_ticket != holdoff_served) begin
      holdoff_served = holdoff_ticket;
      holdoff_left   = HOLDOFF_CYCLES;
    end
    if (holdoff_left != 0) begin
      holdoff_left--;
      stall_next = 1'b1;
    end else begin
      stall_next = ($urandom_range(99) < stall_pct);
    end
    out_stall_i <= stall_next;
  end

  // output word is checked before the event of the same edge is noted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_dab(out_data_o);
      if (in_valid_i && !in_stall_o) sb.note_event(in_data_i);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic longint clamp_coord(longint v);
    return (v > COORD_HI) ? COORD_HI : ((v < COORD_LO) ? COORD_LO : v);
  endfunction

  function automatic longint rand_coord();
    logic [COORD_W-1:0] raw;
    raw = COORD_W'($urandom);
    return longint'($signed(raw));
  endfunction

  task automatic send_event(logic [MODE_W-1:0] mode, longint x, longint y);
    in_item_t ev;
    int       gap;
    ev.mode  = mode;
    ev.x_pos = x[COORD_W-1:0];
    ev.y_pos = y[COORD_W-1:0];
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= ev;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // let the current edge pass first so the last accepted event is already in the scoreboard
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_dabs.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  // a drag that lands on nothing leaves no word behind, so settle before writing
  task automatic apply_settings(logic [31:0] size_val, logic [31:0] color_val,
                                logic [31:0] erase_val);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_write(CFG_SIZE, size_val);
    cfg_write(CFG_COLOR, color_val);
    cfg_write(CFG_ERASE, erase_val);
    cfg_write(CFG_UNUSED, $urandom);
    cfg_we_i <= 1'b0;
  endtask

  task automatic next_point(ref longint x, ref longint y);
    int     r;
    longint span;
    r = $urandom_range(99);
    if (r < 10) return;
    if (r >= 90) begin
      x = rand_coord();
      y = rand_coord();
      return;
    end
    span = longint'(sb.size_reg);
    span = (r < 60) ? span / 2 : span * 2;
    x = clamp_coord(x + longint'($urandom_range(32'(2 * span))) - span);
    y = clamp_coord(y + longint'($urandom_range(32'(2 * span))) - span);
  endtask

  task automatic random_stroke();
    longint x, y;
    int     drags;
    if ($urandom_range(99) < 20)
      send_event(MODE_W'($urandom_range(3)), rand_coord(), rand_coord());
    if ($urandom_range(99) < 15) begin
      x = rand_coord();
      y = rand_coord();
    end else begin
      x = longint'($urandom_range(40000)) - 20000;
      y = longint'($urandom_range(40000)) - 20000;
    end
    send_event(MODE_PRESS, x, y);
    drags = $urandom_range(5);
    repeat (drags) begin
      next_point(x, y);
      send_event(MODE_DRAG, x, y);
    end
    stroke_items += 1 + drags;
    if ($urandom_range(99) < 80) begin
      next_point(x, y);
      send_event(MODE_RELEASE, x, y);
      stroke_items++;
    end
  endtask

  task automatic random_phase(int items);
    stroke_items = 0;
    while (stroke_items < items) random_stroke();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset brush: size 10.0, spacing 1.25
    send_event(MODE_DRAG, 10, 10);
    send_event(MODE_RELEASE, -5, 7);
    send_event(MODE_UNUSED, rand_coord(), rand_coord());
    send_event(MODE_PRESS, COORD_HI, COORD_LO);
    send_event(MODE_DRAG, COORD_LO, COORD_HI);
    send_event(MODE_RELEASE, COORD_LO, COORD_HI);
    send_event(MODE_PRESS, 0, 0);
    send_event(MODE_DRAG, 0, 0);
    send_event(MODE_DRAG, 37, -21);
    send_event(MODE_UNUSED, 500, 500);
    send_event(MODE_PRESS, -100, 55);
    send_event(MODE_DRAG, 60, 20);
    send_event(MODE_RELEASE, -30, 52);

    // size below 1.0 saturates, spacing of two lsb gives rounding ties
    apply_settings(32'd3, 32'hA5C3_0F81, 32'h8000_0001);
    send_event(MODE_PRESS, 0, 0);
    send_event(MODE_DRAG, 3, 0);
    send_event(MODE_DRAG, 0, 0);
    send_event(MODE_DRAG, 0, -4);
    send_event(MODE_RELEASE, 5, 5);

    apply_settings(32'd16383, 32'hFFFF_FFFF, 32'd1);
    random_phase(45);

    apply_settings($urandom, $urandom, 32'd0);
    idle_pct = 85;
    random_phase(45);

    apply_settings(32'd0, 32'd0, 32'd1);
    idle_pct  = 0;
    stall_pct = 85;
    random_phase(40);

    apply_settings({18'($urandom_range(255)), 14'd160}, $urandom, 32'hFFFF_FFFE);
    idle_pct  = 29;
    stall_pct = 29;
    random_phase(20);
    // long receiver hold-off while events keep coming
    holdoff_ticket <= holdoff_ticket + 1;
    random_phase(20);
    wait_drained();
    random_phase(20);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_dabs.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
